// ----- hdl/life_grid_fading_led_effect_macros.svh -----
// ----------------------------------------------------------------------------
// life_grid_fading_led_effect_macros
// assertion macros shared by the life grid effect rtl
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_FADING_LED_EFFECT_MACROS_SVH
`define LIFE_GRID_FADING_LED_EFFECT_MACROS_SVH

// condition holds at every clock edge out of reset
`define LGF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LGF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define LGF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lgf_pkg.sv -----
// ----------------------------------------------------------------------------
// lgf_pkg
// types and constants of the life grid fading led effect
// ----------------------------------------------------------------------------
package lgf_pkg;

    // input item opcodes
    localparam logic [1:0] OP_PRESS = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_SPEED      = 3'd0;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd1;
    localparam logic [2:0] REG_BASE_RED   = 3'd2;
    localparam logic [2:0] REG_BASE_GREEN = 3'd3;
    localparam logic [2:0] REG_BASE_BLUE  = 3'd4;

    // fade constants, q1.15
    localparam logic [15:0] LEVEL_FULL = 16'h8000;
    localparam logic [13:0] FADE_Q15   = 14'd9830;

    // grid coordinate widths, cover the full row and column ranges
    localparam int GRID_ROW_W = 4;
    localparam int GRID_COL_W = 6;

    typedef struct packed {
        logic                  gen;
        logic                  set;
        logic [GRID_ROW_W-1:0] row;
        logic [GRID_COL_W-1:0] col;
    } lgf_grid_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRESS,
        ST_GEN,
        ST_FADE,
        ST_RD_SEEK,
        ST_RD_MEM,
        ST_RD_LB,
        ST_RD_R,
        ST_RD_G,
        ST_RD_B,
        ST_RD_OUT
    } lgf_state_t;

endpackage

// ----- hdl/lgf_life_grid.sv -----
// ----------------------------------------------------------------------------
// lgf_life_grid
// cell array of alive bits: b3/s23 generation step and cluster seeding
// ----------------------------------------------------------------------------
module lgf_life_grid
    import lgf_pkg::*;
#(
    parameter int ROWS = 6,
    parameter int COLS = 22
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lgf_grid_ctrl_t       ctrl,
    output logic [ROWS*COLS-1:0] alive
);

    localparam int CELLS = ROWS * COLS;

    logic [CELLS-1:0] alive_reg;
    logic [CELLS-1:0] alive_next;
    logic [CELLS-1:0] life_next;

    // each cell looks at its own fixed neighbors, no wrap at the edges
    always_comb begin
        logic [3:0] nbr;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                nbr = 4'd0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (!(dr == 0 && dc == 0) && (r + dr >= 0) && (r + dr < ROWS)
                            && (c + dc >= 0) && (c + dc < COLS)) begin
                            nbr = nbr + 4'(alive_reg[(r + dr) * COLS + (c + dc)]);
                        end
                    end
                end
                life_next[r * COLS + c] = alive_reg[r * COLS + c] ?
                    (nbr == 4'd2 || nbr == 4'd3) : (nbr == 4'd3);
            end
        end
    end

    always_comb begin
        alive_next = ctrl.gen ? life_next : alive_reg;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                if (ctrl.set && ctrl.row == GRID_ROW_W'(r) && ctrl.col == GRID_COL_W'(c)) begin
                    alive_next[r * COLS + c] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= '0;
        end else begin
            alive_reg <= alive_next;
        end
    end

    assign alive = alive_reg;

endmodule

// ----- hdl/life_grid_fading_led_effect.sv -----
// ----------------------------------------------------------------------------
// life_grid_fading_led_effect
// game of life key light effect with per-cell fading and colour read-out
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds s_tready low while it works.
// A press inside the grid walks its 3x3 cluster one cell per cycle, writing
// the level memory for each cluster cell inside the grid; a press outside the
// grid and opcode 3 finish in the accept cycle. A tick steps a generation in
// the cell array (ST_GEN) when its interval is met, then the fade sweeps the
// level memory one cell per cycle through the one shared multiplier. A read
// of cell (row, col) walks a snapshot shift line of the alive and valid bits
// to the cell, then makes four passes through the shared multiplier (level
// times brightness, then each colour component) and loads the result into
// the output register. A read outside the grid returns all zeros. The output
// register frees the input side: a new item is taken while a result still
// waits on m_tready. Level memory entries carry valid bits that reset clears,
// so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "life_grid_fading_led_effect_macros.svh"

module life_grid_fading_led_effect
    import lgf_pkg::*;
#(
    parameter int ROWS = 6,
    parameter int COLS = 22
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // grid_row[2:0], grid_col[7:3]
    input  logic [1:0]  s_tuser,    // opcode[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // cell_alive[0], cell_level[16:1], red_out[24:17],
                                    // green_out[32:25], blue_out[40:33], zero fill[47:41]
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(CELLS + 1);

    // state and configuration
    lgf_state_t state_reg, state_next;
    logic [2:0] speed_reg;
    logic [2:0] bright_reg;
    logic [7:0] red_base_reg;
    logic [7:0] green_base_reg;
    logic [7:0] blue_base_reg;
    logic [3:0] tick_count_reg;

    // latched item and sequencer counters
    logic [2:0]        row_reg;
    logic [4:0]        col_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              inside_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [1:0]        dr_reg;
    logic [1:0]        dc_reg;

    // snapshot shift line, bit 0 is the cell being worked on
    logic [CELLS-1:0] sr_alive_reg;
    logic [CELLS-1:0] sr_valid_reg;
    logic [CELLS-1:0] valid_reg;

    // level memory
    logic [15:0]       level_mem [CELLS];
    logic [15:0]       rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_wdata;

    // read datapath
    logic        alive_bit_reg;
    logic        valid_bit_reg;
    logic [15:0] level_reg;
    logic [18:0] prod_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic        m_valid_reg;
    logic [47:0] m_data_reg;

    // shared multiplier
    logic [18:0] mul_a;
    logic [13:0] mul_b;
    logic [32:0] mul_p;

    // grid
    lgf_grid_ctrl_t   grid_ctrl;
    logic [CELLS-1:0] alive_vec;

    // input decode
    logic [1:0]        in_op;
    logic [2:0]        in_row;
    logic [4:0]        in_col;
    logic              in_inside;
    logic [ADDR_W-1:0] in_addr;
    logic              in_accept;

    // tick interval
    logic [3:0] interval;
    logic [3:0] tick_sum;
    logic       tick_gen;
    logic [2:0] br_sat;

    // press cluster walk
    logic [3:0]            pr_rr;
    logic [5:0]            pr_cc;
    logic                  pr_ok;
    logic [GRID_ROW_W-1:0] pr_row;
    logic [GRID_COL_W-1:0] pr_col;
    logic [ADDR_W-1:0]     pr_addr;

    // fade step
    logic [15:0] fd_lv;
    logic [15:0] fd_d;
    logic [32:0] fd_round;
    logic [15:0] fd_step;
    logic [15:0] fd_new;

    logic seek_hit;

    function automatic logic [7:0] colour_sat(input logic [32:0] p);
        logic [15:0] v;
        v = p[32:17];
        return (v > 16'd255) ? 8'hff : v[7:0];
    endfunction

    lgf_life_grid #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_grid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (grid_ctrl),
        .alive   (alive_vec)
    );

    // input fields
    assign in_op     = s_tuser;
    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[7:3];
    assign in_inside = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
    assign in_addr   = ADDR_W'(32'(in_row) * COLS + 32'(in_col));
    assign in_accept = s_tvalid && s_tready;

    // ticks per generation, saturating at 3 for high speeds
    assign interval = (speed_reg >= 3'd4) ? 4'd3 : 4'(5'd15 - 5'(speed_reg) * 5'd3);
    assign tick_sum = tick_count_reg + 4'd1;
    assign tick_gen = (tick_sum >= interval);
    assign br_sat   = (bright_reg > 3'd4) ? 3'd4 : bright_reg;

    // cluster position, offset by one so edges clip without going negative
    assign pr_rr   = 4'(row_reg) + 4'(dr_reg);
    assign pr_cc   = 6'(col_reg) + 6'(dc_reg);
    assign pr_ok   = (pr_rr != 4'd0) && (32'(pr_rr) <= ROWS)
                  && (pr_cc != 6'd0) && (32'(pr_cc) <= COLS);
    assign pr_row  = pr_rr - 4'd1;
    assign pr_col  = pr_cc - 6'd1;
    assign pr_addr = ADDR_W'(32'(pr_row) * COLS + 32'(pr_col));

    // fade toward full or zero, step = ceil(d * 0.3)
    assign fd_lv    = sr_valid_reg[0] ? rdata_reg : 16'd0;
    assign fd_d     = sr_alive_reg[0] ? (LEVEL_FULL - fd_lv) : fd_lv;
    assign fd_round = mul_p + (33'(LEVEL_FULL) - 33'd1);
    assign fd_step  = fd_round[30:15];
    assign fd_new   = sr_alive_reg[0] ? (fd_lv + fd_step) : (fd_lv - fd_step);

    assign mul_p = {14'd0, mul_a} * {19'd0, mul_b};

    assign seek_hit = (idx_reg == IDX_W'(addr_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_op)
                        OP_PRESS: state_next = in_inside ? ST_PRESS : ST_IDLE;
                        OP_TICK:  state_next = tick_gen ? ST_GEN : ST_FADE;
                        OP_READ:  state_next = in_inside ? ST_RD_SEEK : ST_RD_MEM;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PRESS: begin
                if (dr_reg == 2'd2 && dc_reg == 2'd2) state_next = ST_IDLE;
            end
            ST_GEN:  state_next = ST_FADE;
            ST_FADE: begin
                if (idx_reg == IDX_W'(CELLS)) state_next = ST_IDLE;
            end
            ST_RD_SEEK: begin
                if (seek_hit) state_next = ST_RD_MEM;
            end
            ST_RD_MEM: state_next = ST_RD_LB;
            ST_RD_LB:  state_next = ST_RD_R;
            ST_RD_R:   state_next = ST_RD_G;
            ST_RD_G:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_RD_OUT;
            ST_RD_OUT: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        grid_ctrl = '0;
        mem_we    = 1'b0;
        mem_waddr = pr_addr;
        mem_wdata = LEVEL_FULL;
        mem_raddr = addr_reg;
        mul_a     = 19'(fd_d);
        mul_b     = FADE_Q15;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_PRESS: begin
                grid_ctrl.set = pr_ok;
                grid_ctrl.row = pr_row;
                grid_ctrl.col = pr_col;
                mem_we        = pr_ok;
            end
            ST_GEN: grid_ctrl.gen = 1'b1;
            ST_FADE: begin
                // read cell idx while the previous cell is written back
                mem_raddr = (idx_reg < IDX_W'(CELLS)) ? ADDR_W'(idx_reg) : '0;
                if (idx_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(idx_reg - IDX_W'(1));
                    mem_wdata = fd_new;
                end
            end
            ST_RD_LB: begin
                mul_a = 19'(level_reg);
                mul_b = 14'(br_sat);
            end
            ST_RD_R: begin
                mul_a = prod_reg;
                mul_b = 14'(red_base_reg);
            end
            ST_RD_G: begin
                mul_a = prod_reg;
                mul_b = 14'(green_base_reg);
            end
            ST_RD_B: begin
                mul_a = prod_reg;
                mul_b = 14'(blue_base_reg);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            speed_reg      <= 3'd0;
            bright_reg     <= 3'd4;
            red_base_reg   <= 8'd255;
            green_base_reg <= 8'd255;
            blue_base_reg  <= 8'd255;
            tick_count_reg <= 4'd0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
            dr_reg         <= 2'd0;
            dc_reg         <= 2'd0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_SPEED:      speed_reg      <= cfg_wr_data[2:0];
                    REG_BRIGHTNESS: bright_reg     <= cfg_wr_data[2:0];
                    REG_BASE_RED:   red_base_reg   <= cfg_wr_data;
                    REG_BASE_GREEN: green_base_reg <= cfg_wr_data;
                    REG_BASE_BLUE:  blue_base_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end

            if (in_accept && in_op == OP_TICK) begin
                tick_count_reg <= tick_gen ? 4'd0 : tick_sum;
            end

            if (mem_we) valid_reg[mem_waddr] <= 1'b1;

            if (state_reg == ST_RD_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    dr_reg  <= 2'd0;
                    dc_reg  <= 2'd0;
                end
                ST_PRESS: begin
                    if (dc_reg == 2'd2) begin
                        dc_reg <= 2'd0;
                        dr_reg <= dr_reg + 2'd1;
                    end else begin
                        dc_reg <= dc_reg + 2'd1;
                    end
                end
                ST_FADE: idx_reg <= idx_reg + IDX_W'(1);
                ST_RD_SEEK: begin
                    if (!seek_hit) idx_reg <= idx_reg + IDX_W'(1);
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            row_reg       <= in_row;
            col_reg       <= in_col;
            addr_reg      <= in_addr;
            inside_reg    <= in_inside;
            alive_bit_reg <= 1'b0;
            valid_bit_reg <= 1'b0;
            sr_alive_reg  <= alive_vec;
            sr_valid_reg  <= valid_reg;
        end

        case (state_reg)
            ST_FADE: begin
                // first sweep cycle takes the post-generation snapshot
                if (idx_reg == '0) begin
                    sr_alive_reg <= alive_vec;
                    sr_valid_reg <= valid_reg;
                end else begin
                    sr_alive_reg <= {1'b0, sr_alive_reg[CELLS-1:1]};
                    sr_valid_reg <= {1'b0, sr_valid_reg[CELLS-1:1]};
                end
            end
            ST_RD_SEEK: begin
                if (seek_hit) begin
                    alive_bit_reg <= sr_alive_reg[0];
                    valid_bit_reg <= sr_valid_reg[0];
                end else begin
                    sr_alive_reg <= {1'b0, sr_alive_reg[CELLS-1:1]};
                    sr_valid_reg <= {1'b0, sr_valid_reg[CELLS-1:1]};
                end
            end
            ST_RD_MEM: level_reg <= (inside_reg && valid_bit_reg) ? rdata_reg : 16'd0;
            ST_RD_LB:  prod_reg  <= mul_p[18:0];
            ST_RD_R:   red_reg   <= colour_sat(mul_p);
            ST_RD_G:   green_reg <= colour_sat(mul_p);
            ST_RD_B:   blue_reg  <= colour_sat(mul_p);
            ST_RD_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {7'd0, blue_reg, green_reg, red_reg, level_reg, alive_bit_reg};
                end
            end
            default: ;
        endcase
    end

    // level memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) level_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= level_mem[mem_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // counter is cleared once it meets the interval, which never exceeds 15
    `LGF_ASSERT_ALWAYS(a_tick_range, tick_count_reg < 4'd15, "tick counter out of range")
    // a written level never passes full scale
    `LGF_ASSERT_IMPLIES(a_level_bound, mem_we, mem_wdata <= LEVEL_FULL, "level above full")
    // a dark cell reads as black
    `LGF_ASSERT_IMPLIES(a_dark_black, m_tvalid && m_tdata[16:1] == 16'd0,
        m_tdata[40:17] == 24'd0, "colour without level")
    // a tick always starts a generation or a fade sweep
    `LGF_ASSERT_NEXT(a_tick_start, in_accept && in_op == OP_TICK,
        state_reg == ST_GEN || state_reg == ST_FADE, "tick did not start work")

endmodule
